[src/pairwise_cutoff_repulsive_force_defines.svh]
//------------------------------------------------------------------------------
// Pairwise cutoff repulsive force: assertion macros
// Shorthands for the concurrent checks at the end of the top level.
//------------------------------------------------------------------------------
`ifndef PAIRWISE_CUTOFF_REPULSIVE_FORCE_DEFINES_SVH
`define PAIRWISE_CUTOFF_REPULSIVE_FORCE_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while arst_n is low.
`define PCRF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off while arst_n is low.
`define PCRF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pcrf_pkg.sv]
//------------------------------------------------------------------------------
// Pairwise cutoff repulsive force: package
// Shared constants, register map, payload types and the square-root step.
//------------------------------------------------------------------------------
package pcrf_pkg;

	localparam int POS_BITS = 32;
	localparam int USE_BITS = (POS_BITS < 32) ? POS_BITS : 32;
	localparam logic [31:0] POS_MASK = (USE_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << USE_BITS) - 64'd1);

	// Register map
	localparam int ADDR_W = 4;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_CUTOFF = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_RADIUS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_MASS = 2'd2;

	localparam logic [31:0] RST_CUTOFF = 32'd167772;
	localparam logic [31:0] RST_MIN_RADIUS = 32'd1678;
	localparam logic [31:0] RST_INV_MASS = 32'd6553600;

	localparam int SQRT_STAGES = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int DIV_STEPS = 64;

	localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT_NEG_MAG = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [31:0] cutoff;
		logic [31:0] min_radius;
		logic [31:0] inv_mass;
	} cfg_t;

	// One classified pair, handed from the front end to the force unit.
	typedef struct packed {
		logic        in_range;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		logic [31:0] root;
		logic [63:0] r2;
	} pair_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// One digit of the restoring square root: two radicand bits in, one root bit out.
	function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] bits);
		logic [34:0] acc;
		logic [34:0] trial;
		sqrt_t       nxt;
		acc = {cur.rem[32:0], bits};
		trial = {1'b0, cur.root, 2'b01};
		if (acc >= trial) begin
			nxt.rem = acc - trial;
			nxt.root = {cur.root[30:0], 1'b1};
		end else begin
			nxt.rem = acc;
			nxt.root = {cur.root[30:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

[src/pcrf_if.sv]
//------------------------------------------------------------------------------
// Pairwise cutoff repulsive force: channel interfaces
// Valid/ready channels for particle pairs in and force increments out.
//------------------------------------------------------------------------------
interface pcrf_pair_if;
	logic        valid;
	logic        ready;
	logic [31:0] first_x;
	logic [31:0] first_y;
	logic [31:0] second_x;
	logic [31:0] second_y;

	modport source(output valid, first_x, first_y, second_x, second_y, input ready);
	modport sink(input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface pcrf_force_if;
	logic               valid;
	logic               ready;
	logic               in_range;
	logic signed [63:0] accel_inc_x;
	logic signed [63:0] accel_inc_y;
	logic               saturated;

	modport source(output valid, in_range, accel_inc_x, accel_inc_y, saturated, input ready);
	modport sink(input valid, in_range, accel_inc_x, accel_inc_y, saturated, output ready);
endinterface

[src/pairwise_cutoff_repulsive_force.sv]
//------------------------------------------------------------------------------
// Pairwise cutoff repulsive force: top level
// Pair in, acceleration increment out, with an APB register port.
//------------------------------------------------------------------------------
// The pairs channel takes two particle positions (unsigned Q8.24) per request.
// The forces channel returns one result per request, in order: an in-range
// flag, the signed Q40.24 x and y increments for the first particle, and a
// flag that is set when either increment was clipped. Out-of-range pairs give
// zero increments. The caller applies the negated increments to the partner.
// A new pair is accepted every cycle while the queue has room. A request
// passes 20 front-end stages (distance, squares, cutoff check and a
// two-bit-per-stage square root), one queue slot, 4 multiply stages, 64
// division stages (one quotient bit each) and the output register. When the
// receiver stalls, the force unit holds, the four-entry queue fills, then the
// front end holds and deasserts ready. Reset empties the pipeline and queue
// and loads the default registers. The user must write cutoff_radius (0x0),
// min_radius (0x4) and inv_mass (0x8) over APB only while no request is in
// flight; the block itself does not enforce this.
//------------------------------------------------------------------------------
`include "pairwise_cutoff_repulsive_force_defines.svh"

module pairwise_cutoff_repulsive_force (
	input  logic                        clk,
	input  logic                        arst_n,
	pcrf_pair_if.sink                   pairs,
	pcrf_force_if.source                forces,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcrf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	pcrf_pkg::cfg_t       cfg_q;
	logic [pcrf_pkg::REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	logic                 front_valid;
	pcrf_pkg::pair_t      front_data;
	logic                 push;
	logic                 pop;
	pcrf_pkg::pair_t      head;
	pcrf_pkg::fifo_stat_t stat;

	assign pready = 1'b1;
	assign reg_idx = paddr[pcrf_pkg::ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cutoff <= pcrf_pkg::RST_CUTOFF;
			cfg_q.min_radius <= pcrf_pkg::RST_MIN_RADIUS;
			cfg_q.inv_mass <= pcrf_pkg::RST_INV_MASS;
		end else if (wr_en) begin
			unique case (reg_idx)
				pcrf_pkg::REG_CUTOFF: cfg_q.cutoff <= pwdata;
				pcrf_pkg::REG_MIN_RADIUS: cfg_q.min_radius <= pwdata;
				pcrf_pkg::REG_INV_MASS: cfg_q.inv_mass <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pcrf_pkg::REG_CUTOFF: prdata = cfg_q.cutoff;
			pcrf_pkg::REG_MIN_RADIUS: prdata = cfg_q.min_radius;
			pcrf_pkg::REG_INV_MASS: prdata = cfg_q.inv_mass;
			default: prdata = 32'd0;
		endcase
	end

	pcrf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pairs     (pairs),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_ready (!stat.full),
		.out_data  (front_data)
	);

	assign push = front_valid && !stat.full;

	pcrf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_data),
		.pop       (pop),
		.pop_data  (head),
		.stat      (stat)
	);

	pcrf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.stat   (stat),
		.head   (head),
		.pop    (pop),
		.forces (forces)
	);

	`PCRF_ASSERT_IMP(a_oor_zero, forces.valid && !forces.in_range, forces.accel_inc_x == 64'sd0 && forces.accel_inc_y == 64'sd0 && !forces.saturated, "out-of-range result carries a nonzero increment")
	`PCRF_ASSERT_IMP(a_sat_in_range, forces.valid && forces.saturated, forces.in_range, "saturation flagged on an out-of-range result")
	`PCRF_ASSERT_NXT(a_cfg_cutoff, wr_en && reg_idx == pcrf_pkg::REG_CUTOFF, cfg_q.cutoff == $past(pwdata), "cutoff register did not take the written value")

endmodule

[src/pcrf_front.sv]
//------------------------------------------------------------------------------
// Pairwise cutoff repulsive force: front end
// Takes pair requests, forms distances, checks the cutoff and takes the root.
//------------------------------------------------------------------------------
module pcrf_front (
	input  logic            clk,
	input  logic            arst_n,
	pcrf_pair_if.sink       pairs,
	input  pcrf_pkg::cfg_t  cfg,
	output logic            out_valid,
	input  logic            out_ready,
	output pcrf_pkg::pair_t out_data
);

	typedef struct packed {
		pcrf_pkg::sqrt_t st;
		logic [63:0]     bits;
		logic [63:0]     r2;
		logic            in_range;
		logic            neg_x;
		logic            neg_y;
		logic [31:0]     mag_x;
		logic [31:0]     mag_y;
	} sq_stage_t;

	function automatic sq_stage_t sq_adv(sq_stage_t c);
		sq_stage_t n;
		n = c;
		n.st = pcrf_pkg::sqrt_step(pcrf_pkg::sqrt_step(c.st, c.bits[63:62]), c.bits[61:60]);
		n.bits = {c.bits[59:0], 4'b0000};
		return n;
	endfunction

	logic        en;
	logic [32:0] dx;
	logic [32:0] dy;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2, neg_x_s3, neg_y_s3;
	logic        neg_x_s4, neg_y_s4;
	logic [31:0] mag_x_s1, mag_y_s1, mag_x_s2, mag_y_s2, mag_x_s3, mag_y_s3;
	logic [31:0] mag_x_s4, mag_y_s4;
	logic [63:0] sq_x_s2, sq_y_s2, cut2_s2, min2_s2, cut2_s3, min2_s3;
	logic [64:0] sum_s3;
	logic [63:0] r2_s4;
	logic        in_range_s4;

	logic [63:0] r2_clamp;
	logic        out_of_range;

	sq_stage_t sq_in [pcrf_pkg::SQRT_STAGES];
	sq_stage_t sq_s [pcrf_pkg::SQRT_STAGES];
	logic [pcrf_pkg::SQRT_STAGES-1:0] v_sq;

	assign en = !v_sq[pcrf_pkg::SQRT_STAGES-1] || out_ready;
	assign pairs.ready = en;

	assign dx = {1'b0, pairs.second_x & pcrf_pkg::POS_MASK} -
		{1'b0, pairs.first_x & pcrf_pkg::POS_MASK};
	assign dy = {1'b0, pairs.second_y & pcrf_pkg::POS_MASK} -
		{1'b0, pairs.first_y & pcrf_pkg::POS_MASK};

	// A squared distance that overflows 64 bits is out of range as well.
	always_comb begin
		out_of_range = sum_s3[64] || (sum_s3[63:0] > cut2_s3);
		r2_clamp = (sum_s3[63:0] < min2_s3) ? min2_s3 : sum_s3[63:0];
		if (r2_clamp == 64'd0) begin
			r2_clamp = 64'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_s1 <= dx[32];
			neg_y_s1 <= dy[32];
			mag_x_s1 <= dx[32] ? 32'(-dx) : dx[31:0];
			mag_y_s1 <= dy[32] ? 32'(-dy) : dy[31:0];

			sq_x_s2 <= mag_x_s1 * mag_x_s1;
			sq_y_s2 <= mag_y_s1 * mag_y_s1;
			cut2_s2 <= cfg.cutoff * cfg.cutoff;
			min2_s2 <= cfg.min_radius * cfg.min_radius;
			{neg_x_s2, neg_y_s2, mag_x_s2, mag_y_s2} <= {neg_x_s1, neg_y_s1, mag_x_s1, mag_y_s1};

			sum_s3 <= {1'b0, sq_x_s2} + {1'b0, sq_y_s2};
			cut2_s3 <= cut2_s2;
			min2_s3 <= min2_s2;
			{neg_x_s3, neg_y_s3, mag_x_s3, mag_y_s3} <= {neg_x_s2, neg_y_s2, mag_x_s2, mag_y_s2};

			r2_s4 <= r2_clamp;
			in_range_s4 <= !out_of_range;
			{neg_x_s4, neg_y_s4, mag_x_s4, mag_y_s4} <= {neg_x_s3, neg_y_s3, mag_x_s3, mag_y_s3};
		end
	end

	always_comb begin
		sq_in[0].st = '0;
		sq_in[0].bits = r2_s4;
		sq_in[0].r2 = r2_s4;
		sq_in[0].in_range = in_range_s4;
		sq_in[0].neg_x = neg_x_s4;
		sq_in[0].neg_y = neg_y_s4;
		sq_in[0].mag_x = mag_x_s4;
		sq_in[0].mag_y = mag_y_s4;
	end

	for (genvar k = 0; k < pcrf_pkg::SQRT_STAGES; k++) begin : g_sqrt
		if (k > 0) begin : g_link
			assign sq_in[k] = sq_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k] <= sq_adv(sq_in[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_sq <= '0;
		end else if (en) begin
			v_s1 <= pairs.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sq <= {v_sq[pcrf_pkg::SQRT_STAGES-2:0], v_s4};
		end
	end

	assign out_valid = v_sq[pcrf_pkg::SQRT_STAGES-1];

	always_comb begin
		out_data.in_range = sq_s[pcrf_pkg::SQRT_STAGES-1].in_range;
		out_data.neg_x = sq_s[pcrf_pkg::SQRT_STAGES-1].neg_x;
		out_data.neg_y = sq_s[pcrf_pkg::SQRT_STAGES-1].neg_y;
		out_data.mag_x = sq_s[pcrf_pkg::SQRT_STAGES-1].mag_x;
		out_data.mag_y = sq_s[pcrf_pkg::SQRT_STAGES-1].mag_y;
		out_data.root = sq_s[pcrf_pkg::SQRT_STAGES-1].st.root;
		out_data.r2 = sq_s[pcrf_pkg::SQRT_STAGES-1].r2;
	end

endmodule

[src/pcrf_fifo.sv]
//------------------------------------------------------------------------------
// Pairwise cutoff repulsive force: pair queue
// Short queue between the front end and the force unit.
//------------------------------------------------------------------------------
module pcrf_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pcrf_pkg::pair_t      push_data,
	input  logic                 pop,
	output pcrf_pkg::pair_t      pop_data,
	output pcrf_pkg::fifo_stat_t stat
);

	pcrf_pkg::pair_t                 mem_q [pcrf_pkg::FIFO_DEPTH];
	logic [pcrf_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [pcrf_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [pcrf_pkg::FIFO_CNT_W-1:0] cnt_q;

	assign stat.full = (cnt_q == pcrf_pkg::FIFO_CNT_W'(pcrf_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/pcrf_div.sv]
//------------------------------------------------------------------------------
// Pairwise cutoff repulsive force: quotient pipeline
// Restoring division, one quotient bit per stage, 64 stages.
//------------------------------------------------------------------------------
module pcrf_div (
	input  logic        clk,
	input  logic        en,
	input  logic [95:0] num,
	input  logic [95:0] den,
	output logic [63:0] quot,
	output logic        huge
);

	typedef struct packed {
		logic [95:0] rem;
		logic [63:0] dvd;
		logic [95:0] den;
		logic [63:0] quo;
		logic        huge;
	} div_stage_t;

	function automatic div_stage_t div_step(div_stage_t c);
		logic [96:0] t;
		div_stage_t  n;
		n = c;
		t = {c.rem, c.dvd[63]};
		if (t >= {1'b0, c.den}) begin
			n.rem = 96'(t - {1'b0, c.den});
			n.quo = {c.quo[62:0], 1'b1};
		end else begin
			n.rem = t[95:0];
			n.quo = {c.quo[62:0], 1'b0};
		end
		n.dvd = {c.dvd[62:0], 1'b0};
		return n;
	endfunction

	div_stage_t st_in [pcrf_pkg::DIV_STEPS];
	div_stage_t st_s [pcrf_pkg::DIV_STEPS];

	// The full dividend is num * 2^32; a quotient of 2^64 or more shows up
	// as the upper dividend bits already reaching the divisor.
	always_comb begin
		st_in[0].rem = {32'd0, num[95:32]};
		st_in[0].dvd = {num[31:0], 32'd0};
		st_in[0].den = den;
		st_in[0].quo = '0;
		st_in[0].huge = ({32'd0, num[95:32]} >= den);
	end

	for (genvar k = 0; k < pcrf_pkg::DIV_STEPS; k++) begin : g_step
		if (k > 0) begin : g_link
			assign st_in[k] = st_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= div_step(st_in[k]);
			end
		end
	end

	assign quot = st_s[pcrf_pkg::DIV_STEPS-1].quo;
	assign huge = st_s[pcrf_pkg::DIV_STEPS-1].huge;

endmodule

[src/pcrf_back.sv]
//------------------------------------------------------------------------------
// Pairwise cutoff repulsive force: force unit
// Builds numerator and denominator, divides, saturates and signs the result.
//------------------------------------------------------------------------------
module pcrf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcrf_pkg::cfg_t       cfg,
	input  pcrf_pkg::fifo_stat_t stat,
	input  pcrf_pkg::pair_t      head,
	output logic                 pop,
	pcrf_force_if.source         forces
);

	typedef struct packed {
		logic v;
		logic in_range;
		logic neg_x;
		logic neg_y;
	} side_t;

	logic        en;
	logic        neg_r;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        in_range_s1, in_range_s2, in_range_s3, in_range_s4;
	logic        neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2, neg_x_s3, neg_y_s3;
	logic        neg_x_s4, neg_y_s4;
	logic [31:0] a_s1, root_s1, mag_x_s1, mag_y_s1, mag_x_s2, mag_y_s2;
	logic [63:0] r2_s1, am_s2, dlo_s2, dhi_s2;
	logic [63:0] pxl_s3, pxh_s3, pyl_s3, pyh_s3;
	logic [95:0] den_s3, den_s4, numx_s4, numy_s4;

	side_t side_s [pcrf_pkg::DIV_STEPS];

	logic [63:0] quot_x, quot_y;
	logic        huge_x, huge_y;
	logic [63:0] mag_x, mag_y, lim_x, lim_y, clip_x, clip_y;
	logic        sat_x, sat_y;
	side_t       last;

	logic               out_v_q;
	logic               in_range_q;
	logic signed [63:0] inc_x_q, inc_y_q;
	logic               sat_q;

	assign en = !out_v_q || forces.ready;
	assign pop = en && !stat.empty;
	assign neg_r = head.root < cfg.cutoff;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= neg_r ? cfg.cutoff - head.root : head.root - cfg.cutoff;
			neg_x_s1 <= neg_r ^ head.neg_x;
			neg_y_s1 <= neg_r ^ head.neg_y;
			in_range_s1 <= head.in_range;
			root_s1 <= head.root;
			r2_s1 <= head.r2;
			mag_x_s1 <= head.mag_x;
			mag_y_s1 <= head.mag_y;

			am_s2 <= a_s1 * cfg.inv_mass;
			dlo_s2 <= r2_s1[31:0] * root_s1;
			dhi_s2 <= r2_s1[63:32] * root_s1;
			{in_range_s2, neg_x_s2, neg_y_s2} <= {in_range_s1, neg_x_s1, neg_y_s1};
			{mag_x_s2, mag_y_s2} <= {mag_x_s1, mag_y_s1};

			den_s3 <= {32'd0, dlo_s2} + {dhi_s2, 32'd0};
			pxl_s3 <= am_s2[31:0] * mag_x_s2;
			pxh_s3 <= am_s2[63:32] * mag_x_s2;
			pyl_s3 <= am_s2[31:0] * mag_y_s2;
			pyh_s3 <= am_s2[63:32] * mag_y_s2;
			{in_range_s3, neg_x_s3, neg_y_s3} <= {in_range_s2, neg_x_s2, neg_y_s2};

			den_s4 <= den_s3;
			numx_s4 <= {32'd0, pxl_s3} + {pxh_s3, 32'd0};
			numy_s4 <= {32'd0, pyl_s3} + {pyh_s3, 32'd0};
			{in_range_s4, neg_x_s4, neg_y_s4} <= {in_range_s3, neg_x_s3, neg_y_s3};
		end
	end

	pcrf_div u_div_x (
		.clk  (clk),
		.en   (en),
		.num  (numx_s4),
		.den  (den_s4),
		.quot (quot_x),
		.huge (huge_x)
	);

	pcrf_div u_div_y (
		.clk  (clk),
		.en   (en),
		.num  (numy_s4),
		.den  (den_s4),
		.quot (quot_y),
		.huge (huge_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < pcrf_pkg::DIV_STEPS; i++) begin
				side_s[i] <= '0;
			end
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= !stat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			side_s[0] <= '{v: v_s4, in_range: in_range_s4, neg_x: neg_x_s4, neg_y: neg_y_s4};
			for (int i = 1; i < pcrf_pkg::DIV_STEPS; i++) begin
				side_s[i] <= side_s[i-1];
			end
			out_v_q <= side_s[pcrf_pkg::DIV_STEPS-1].v;
		end
	end

	// A negative increment may reach one step further than a positive one.
	always_comb begin
		last = side_s[pcrf_pkg::DIV_STEPS-1];
		mag_x = huge_x ? 64'hFFFF_FFFF_FFFF_FFFF : quot_x;
		mag_y = huge_y ? 64'hFFFF_FFFF_FFFF_FFFF : quot_y;
		lim_x = last.neg_x ? pcrf_pkg::SAT_NEG_MAG : pcrf_pkg::SAT_POS;
		lim_y = last.neg_y ? pcrf_pkg::SAT_NEG_MAG : pcrf_pkg::SAT_POS;
		sat_x = mag_x > lim_x;
		sat_y = mag_y > lim_y;
		clip_x = sat_x ? lim_x : mag_x;
		clip_y = sat_y ? lim_y : mag_y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_range_q <= last.in_range;
			if (last.in_range) begin
				inc_x_q <= last.neg_x ? $signed(~clip_x + 64'd1) : $signed(clip_x);
				inc_y_q <= last.neg_y ? $signed(~clip_y + 64'd1) : $signed(clip_y);
				sat_q <= sat_x || sat_y;
			end else begin
				inc_x_q <= '0;
				inc_y_q <= '0;
				sat_q <= 1'b0;
			end
		end
	end

	assign forces.valid = out_v_q;
	assign forces.in_range = in_range_q;
	assign forces.accel_inc_x = inc_x_q;
	assign forces.accel_inc_y = inc_y_q;
	assign forces.saturated = sat_q;

endmodule

[bench/pairwise_cutoff_repulsive_force_tb.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Pairwise cutoff repulsive force: testbench
// Drives particle pairs through the block under several register settings and
// idle patterns, predicts each force increment with exact wide arithmetic and
// compares every result with the oldest outstanding prediction.
//------------------------------------------------------------------------------
module pairwise_cutoff_repulsive_force_tb;

	typedef struct {
		logic        in_range;
		logic [63:0] inc_x;
		logic [63:0] inc_y;
		logic        saturated;
	} force_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pcrf_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pcrf_pair_if pairs_if();
	pcrf_force_if forces_if();

	pairwise_cutoff_repulsive_force dut (
		.clk(clk), .arst_n(arst_n), .pairs(pairs_if), .forces(forces_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// Register shadows used by the force predictor.
	logic [31:0] cfg_cutoff = pcrf_pkg::RST_CUTOFF;
	logic [31:0] cfg_min = pcrf_pkg::RST_MIN_RADIUS;
	logic [31:0] cfg_mass = pcrf_pkg::RST_INV_MASS;

	force_t pending_forces[$];
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;

	initial begin
		pairs_if.valid = 1'b0;
		pairs_if.first_x = '0;
		pairs_if.first_y = '0;
		pairs_if.second_x = '0;
		pairs_if.second_y = '0;
		forces_if.ready = 1'b0;
	end

	function automatic logic [31:0] floor_sqrt(logic [63:0] v);
		logic [31:0] res;
		logic [31:0] cand;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			cand = res | (32'd1 << i);
			if (64'(cand) * 64'(cand) <= v)
				res = cand;
		end
		return res;
	endfunction

	function automatic logic [63:0] axis_force(logic [31:0] r, logic [63:0] r2,
			logic signed [33:0] d, inout logic sat);
		logic [191:0] num;
		logic [191:0] den;
		logic [191:0] quo;
		logic [191:0] limit;
		logic [31:0] gap;
		logic [31:0] mag_d;
		logic neg;
		neg = (r < cfg_cutoff);
		gap = neg ? cfg_cutoff - r : r - cfg_cutoff;
		mag_d = (d < 0) ? 32'(-d) : 32'(d);
		if (d < 0)
			neg = ~neg;
		num = 192'(gap);
		num = num * 192'(cfg_mass);
		num = num * 192'(mag_d);
		num = num << 32;
		den = 192'(r) * 192'(r2);
		quo = num / den;
		limit = neg ? 192'(pcrf_pkg::SAT_NEG_MAG) : 192'(pcrf_pkg::SAT_POS);
		if (quo > limit) begin
			quo = limit;
			sat = 1'b1;
		end
		return neg ? -quo[63:0] : quo[63:0];
	endfunction

	function automatic force_t predict_force(logic [31:0] fx, logic [31:0] fy,
			logic [31:0] sx, logic [31:0] sy);
		force_t f;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [64:0] r2_full;
		logic [63:0] r2;
		logic [31:0] r;
		logic sat;
		dx = $signed({2'b0, sx & pcrf_pkg::POS_MASK}) - $signed({2'b0, fx & pcrf_pkg::POS_MASK});
		dy = $signed({2'b0, sy & pcrf_pkg::POS_MASK}) - $signed({2'b0, fy & pcrf_pkg::POS_MASK});
		ax = (dx < 0) ? 32'(-dx) : 32'(dx);
		ay = (dy < 0) ? 32'(-dy) : 32'(dy);
		r2_full = 65'(64'(ax) * 64'(ax)) + 65'(64'(ay) * 64'(ay));
		f = '{1'b0, 64'd0, 64'd0, 1'b0};
		if (r2_full[64] || r2_full[63:0] > 64'(cfg_cutoff) * 64'(cfg_cutoff))
			return f;
		r2 = r2_full[63:0];
		if (r2 < 64'(cfg_min) * 64'(cfg_min))
			r2 = 64'(cfg_min) * 64'(cfg_min);
		if (r2 == 0)
			r2 = 64'd1;
		r = floor_sqrt(r2);
		sat = 1'b0;
		f.in_range = 1'b1;
		f.inc_x = axis_force(r, r2, dx, sat);
		f.inc_y = axis_force(r, r2, dy, sat);
		f.saturated = sat;
		return f;
	endfunction

	// Receiver: random stalls, or a long hold-off while hold_left counts down.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			forces_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			forces_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		force_t want;
		if (arst_n && forces_if.valid && forces_if.ready) begin
			if (pending_forces.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: x=%h y=%h", forces_if.accel_inc_x,
						forces_if.accel_inc_y);
			end else begin
				want = pending_forces.pop_front();
				if (forces_if.in_range !== want.in_range
						|| forces_if.accel_inc_x !== want.inc_x
						|| forces_if.accel_inc_y !== want.inc_y
						|| forces_if.saturated !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp rng=%b x=%h y=%h sat=%b, got rng=%b x=%h y=%h sat=%b",
							want.in_range, want.inc_x, want.inc_y, want.saturated,
							forces_if.in_range, forces_if.accel_inc_x,
							forces_if.accel_inc_y, forces_if.saturated);
				end
			end
		end
	end

	// Sends one pair; called and returning at a falling edge. Valid stays high
	// on return so that back-to-back requests follow each other without a gap.
	task automatic send_pair(logic [31:0] fx, logic [31:0] fy, logic [31:0] sx,
			logic [31:0] sy);
		while ($urandom_range(99) < idle_pct) begin
			pairs_if.valid = 1'b0;
			@(negedge clk);
		end
		pairs_if.valid = 1'b1;
		pairs_if.first_x = fx;
		pairs_if.first_y = fy;
		pairs_if.second_x = sx;
		pairs_if.second_y = sy;
		@(posedge clk);
		while (!pairs_if.ready)
			@(posedge clk);
		pending_forces.insert(pending_forces.size(), predict_force(fx, fy, sx, sy));
		@(negedge clk);
	endtask

	task automatic drain;
		pairs_if.valid = 1'b0;
		wait (pending_forces.size() == 0);
		repeat (100) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [pcrf_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			pcrf_pkg::REG_CUTOFF: cfg_cutoff = value;
			pcrf_pkg::REG_MIN_RADIUS: cfg_min = value;
			default: cfg_mass = value;
		endcase
	endtask

	task automatic set_config(logic [31:0] cutoff, logic [31:0] min_r, logic [31:0] mass);
		drain();
		write_reg(pcrf_pkg::REG_CUTOFF, cutoff);
		write_reg(pcrf_pkg::REG_MIN_RADIUS, min_r);
		write_reg(pcrf_pkg::REG_INV_MASS, mass);
	endtask

	// Mostly nearby pairs so that the force path is exercised, some far apart.
	task automatic send_random_pair;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] span;
		fx = $urandom();
		fy = $urandom();
		span = (cfg_cutoff > 32'h3FFF_FFFF) ? 32'h7FFF_FFFF : cfg_cutoff * 2 + 2;
		if ($urandom_range(99) < 75)
			send_pair(fx, fy, fx + $urandom_range(span) - span / 2,
				fy + $urandom_range(span) - span / 2);
		else
			send_pair(fx, fy, $urandom(), $urandom());
	endtask

	task automatic test_directed;
		idle_pct = 0;
		stall_pct = 0;
		send_pair(32'd0, 32'd0, 32'd0, 32'd0);
		send_pair(32'h1000_0000, 32'h1000_0000, 32'h1000_0001, 32'h1000_0000);
		send_pair(32'h2000_0000, 32'h2000_0000, 32'h2000_0000 - 32'd100000, 32'h2000_0000);
		send_pair(32'h0, 32'h0, 32'd167772, 32'd0);
		send_pair(32'h0, 32'h0, 32'd167773, 32'd0);
		send_pair(32'h0, 32'h0, 32'd118631, 32'd118631);
		send_pair(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5560, 32'hAAAA_AAA0);
		// Cutoff and mass at their largest: tiny separations clip the increments.
		set_config(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
		send_pair(32'd5, 32'd5, 32'd6, 32'd5);
		send_pair(32'd5, 32'd5, 32'd5, 32'd4);
		send_pair(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
		send_pair(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(32'h8000_0000, 32'h0, 32'h0, 32'hB504_F333);
		// A zero minimum radius with coincident particles.
		set_config(32'd1000, 32'd0, 32'd65536);
		send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
		send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5679, 32'h9ABC_DEF0);
		// Minimum radius beyond the cutoff turns the force attractive.
		set_config(32'd1000, 32'd5000, 32'd1);
		send_pair(32'd100, 32'd100, 32'd400, 32'd500);
		send_pair(32'd100, 32'd100, 32'd1100, 32'd100);
		send_pair(32'd100, 32'd100, 32'd1101, 32'd100);
		drain();
	endtask

	task automatic test_random_phase(int count, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			send_random_pair();
		drain();
	endtask

	// The hold-off outlasts the whole pipeline, so the input stalls as well.
	task automatic test_backpressure;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 400;
		repeat (200)
			send_random_pair();
		drain();
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		set_config(pcrf_pkg::RST_CUTOFF, pcrf_pkg::RST_MIN_RADIUS, pcrf_pkg::RST_INV_MASS);
		test_random_phase(250, 0, 0);
		test_random_phase(150, 88, 0);
		set_config(32'h0100_0000, 32'd1, 32'hFFFF_FFFF);
		test_random_phase(150, 0, 88);
		test_random_phase(150, 13, 13);
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
		test_random_phase(120, 0, 0);
		set_config(32'd20000, 32'd50000, 32'h0001_0000);
		test_random_phase(150, 13, 13);
		set_config(32'd1, 32'd1, 32'd1);
		test_random_phase(100, 0, 88);
		set_config(32'h0400_0000, 32'd1678, 32'h8000_0000);
		test_backpressure();
		test_random_phase(100, 0, 0);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/pcrf_pkg.sv
src/pcrf_if.sv
src/pcrf_front.sv
src/pcrf_fifo.sv
src/pcrf_div.sv
src/pcrf_back.sv
src/pairwise_cutoff_repulsive_force.sv
bench/pairwise_cutoff_repulsive_force_tb.sv
